// ===== rtl/core/rgb_linear_fade_engine_defines.svh =====
// assertion macros for the rgb linear fade engine
`ifndef RGB_LINEAR_FADE_ENGINE_DEFINES_SVH
`define RGB_LINEAR_FADE_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define RFE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define RFE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define RFE_ASSERT(label, prop, msg)
`define RFE_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/core/rfe_pkg.sv =====
// types and constants shared by the rgb linear fade engine
`timescale 1ns / 1ps
`default_nettype none

package rfe_pkg;

   localparam int COLOR_WIDTH  = 8;
   localparam int FADE_WIDTH   = 16;
   localparam int PERIOD_WIDTH = 10;
   localparam int NUM_CHAN     = 3;

   localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 10'd34;
   localparam logic [1:0]              LAST_CHAN    = 2'd2;

   localparam logic REQ_COLOR = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   typedef struct packed {
      logic                   req_type;
      logic [COLOR_WIDTH-1:0] target_red;
      logic [COLOR_WIDTH-1:0] target_green;
      logic [COLOR_WIDTH-1:0] target_blue;
      logic [FADE_WIDTH-1:0]  fade_time_ms;
   } rfe_req_type;

   typedef struct packed {
      logic [COLOR_WIDTH-1:0] red_drive;
      logic [COLOR_WIDTH-1:0] green_drive;
      logic [COLOR_WIDTH-1:0] blue_drive;
      logic                   fading;
      logic                   color_updated;
   } rfe_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FRAMES,
      ST_LAUNCH,
      ST_STEP,
      ST_TICK,
      ST_FINISH
   } rfe_state_type;

endpackage

`default_nettype wire

// ===== rtl/core/rfe_div.sv =====
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module rfe_div
   import rfe_pkg::*;
#(
   parameter int NUM_WIDTH = 24
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [NUM_WIDTH-1:0]  numer,
   input  wire logic [FADE_WIDTH-1:0] denom,
   output logic                       done,
   output logic [NUM_WIDTH-1:0]       quotient
);

   localparam int CW = $clog2(NUM_WIDTH + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CW-1:0]         count_ff;
   logic [FADE_WIDTH-1:0] rem_ff;
   logic [FADE_WIDTH-1:0] den_ff;
   logic [NUM_WIDTH-1:0]  quo_ff;

   logic [FADE_WIDTH:0]   shifted;
   logic [FADE_WIDTH:0]   trial;
   logic                  fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_WIDTH-1]};
      fits    = (shifted >= {1'b0, den_ff});
      trial   = shifted - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CW'(NUM_WIDTH);
         end else if (busy_ff) begin
            count_ff <= count_ff - CW'(1);
            if (count_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         den_ff <= denom;
         quo_ff <= numer;
      end else if (busy_ff) begin
         rem_ff <= fits ? trial[FADE_WIDTH-1:0] : shifted[FADE_WIDTH-1:0];
         quo_ff <= {quo_ff[NUM_WIDTH-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rgb_linear_fade_engine.sv =====
// top level of the rgb linear fade engine
//
// req channel: one transaction is either a color command (target rgb and a fade
// time in ms) or a one millisecond tick. rsp channel: one transaction per request
// with the inverted drive levels, the fading flag and a color changed flag.
// csr port: csr_wr_en writes csr_wr_data into the frame period register.
// one request is worked on at a time; req_stall is high until it is finished.
// a tick goes through the tick and finish states before rsp_valid is registered,
// and the engine then returns to idle for the next request. a color command divides
// once for the frame count and, if that count is nonzero, once for each color
// channel; a zero frame count ends after the first division. all divisions run
// on the shared divider, which makes one quotient bit per cycle.
// the result sits in an output register; a new request is taken while it waits.
// if rsp_stall is high the engine holds the result and finishes the next request
// only up to the point of handing it over.
// synchronous reset clears the shown color to black, stops any fade and loads
// a frame period of 34 ms.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_linear_fade_engine_defines.svh"

module rgb_linear_fade_engine
   import rfe_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire rfe_req_type             req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output rfe_rsp_type                  rsp_data,
   input  wire logic                    csr_wr_en,
   input  wire logic [PERIOD_WIDTH-1:0] csr_wr_data
);

   localparam int LW = COLOR_WIDTH + FRACTION_BITS;
   localparam int SW = LW + 1;

   rfe_state_type state_ff, state_in;

   logic [PERIOD_WIDTH-1:0] period_ff;
   logic [PERIOD_WIDTH-1:0] period_eff;
   rfe_req_type             req_ff;
   logic [COLOR_WIDTH-1:0]  before_ff [NUM_CHAN];
   logic [LW-1:0]           shown_ff  [NUM_CHAN];
   logic signed [SW-1:0]    step_ff   [NUM_CHAN];
   logic [COLOR_WIDTH-1:0]  target_ff [NUM_CHAN];
   logic [FADE_WIDTH-1:0]   frames_ff;
   logic [FADE_WIDTH-1:0]   frames_left_ff;
   logic [PERIOD_WIDTH-1:0] ms_ff;
   logic                    fade_active_ff;
   logic [1:0]              chan_ff;
   logic                    rsp_valid_ff;
   rfe_rsp_type             rsp_data_ff;

   logic [COLOR_WIDTH-1:0]  req_tgt   [NUM_CHAN];
   logic [COLOR_WIDTH-1:0]  shown_int [NUM_CHAN];
   logic [COLOR_WIDTH-1:0]  cur_int;
   logic [COLOR_WIDTH-1:0]  sel_tgt;
   logic [COLOR_WIDTH-1:0]  diff;
   logic                    neg;
   logic [LW-1:0]           mag;
   logic signed [SW-1:0]    step_new;
   logic                    frame_end;
   logic                    out_free;
   logic                    accept;
   rfe_rsp_type             rsp_build;

   logic                    div_start;
   logic [LW-1:0]           div_num;
   logic [FADE_WIDTH-1:0]   div_den;
   logic                    div_done;
   logic [LW-1:0]           div_quotient;

   rfe_div #(
      .NUM_WIDTH (LW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_num),
      .denom    (div_den),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign period_eff = (period_ff == '0) ? PERIOD_WIDTH'(1) : period_ff;
   assign accept     = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign frame_end  = ({1'b0, ms_ff} + (PERIOD_WIDTH + 1)'(1)) >= {1'b0, period_eff};

   always_comb begin
      req_tgt[0] = req_ff.target_red;
      req_tgt[1] = req_ff.target_green;
      req_tgt[2] = req_ff.target_blue;
      for (int c = 0; c < NUM_CHAN; c++) begin
         shown_int[c] = shown_ff[c][LW-1 -: COLOR_WIDTH];
      end
   end

   // operands and signed result of the per-channel step division
   always_comb begin
      cur_int  = shown_int[chan_ff];
      sel_tgt  = req_tgt[chan_ff];
      neg      = sel_tgt < cur_int;
      diff     = neg ? (cur_int - sel_tgt) : (sel_tgt - cur_int);
      mag      = {diff, {FRACTION_BITS{1'b0}}};
      step_new = neg ? -$signed({1'b0, div_quotient}) : $signed({1'b0, div_quotient});
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.req_type == REQ_TICK) ? ST_TICK : ST_FRAMES;
            end
         end
         ST_FRAMES: begin
            if (div_done) begin
               state_in = (div_quotient == '0) ? ST_FINISH : ST_LAUNCH;
            end
         end
         ST_LAUNCH: state_in = ST_STEP;
         ST_STEP: begin
            if (div_done) begin
               state_in = (chan_ff == LAST_CHAN) ? ST_FINISH : ST_LAUNCH;
            end
         end
         ST_TICK: state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      div_start = 1'b0;
      div_num   = mag;
      div_den   = frames_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            div_start = req_valid && (req_data.req_type == REQ_COLOR);
            div_num   = LW'(req_data.fade_time_ms);
            div_den   = FADE_WIDTH'(period_eff);
         end
         ST_LAUNCH: div_start = 1'b1;
         default: div_start = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         period_ff      <= PERIOD_RESET;
         frames_ff      <= '0;
         frames_left_ff <= '0;
         ms_ff          <= '0;
         fade_active_ff <= 1'b0;
         chan_ff        <= '0;
         for (int c = 0; c < NUM_CHAN; c++) begin
            shown_ff[c]  <= '0;
            step_ff[c]   <= '0;
            target_ff[c] <= '0;
            before_ff[c] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            period_ff <= csr_wr_data;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  req_ff <= req_data;
                  for (int c = 0; c < NUM_CHAN; c++) begin
                     before_ff[c] <= shown_int[c];
                  end
               end
            end
            ST_FRAMES: begin
               if (div_done) begin
                  ms_ff     <= '0;
                  frames_ff <= div_quotient[FADE_WIDTH-1:0];
                  chan_ff   <= '0;
                  for (int c = 0; c < NUM_CHAN; c++) begin
                     target_ff[c] <= req_tgt[c];
                  end
                  if (div_quotient == '0) begin
                     frames_left_ff <= '0;
                     fade_active_ff <= 1'b0;
                     for (int c = 0; c < NUM_CHAN; c++) begin
                        shown_ff[c] <= {req_tgt[c], {FRACTION_BITS{1'b0}}};
                        step_ff[c]  <= '0;
                     end
                  end else begin
                     // restart from the shown integer color
                     for (int c = 0; c < NUM_CHAN; c++) begin
                        shown_ff[c] <= {shown_int[c], {FRACTION_BITS{1'b0}}};
                     end
                  end
               end
            end
            ST_STEP: begin
               if (div_done) begin
                  step_ff[chan_ff] <= step_new;
                  if (chan_ff == LAST_CHAN) begin
                     frames_left_ff <= frames_ff;
                     fade_active_ff <= 1'b1;
                  end else begin
                     chan_ff <= chan_ff + 2'd1;
                  end
               end
            end
            ST_TICK: begin
               if (fade_active_ff) begin
                  if (frame_end) begin
                     ms_ff          <= '0;
                     frames_left_ff <= frames_left_ff - FADE_WIDTH'(1);
                     if (frames_left_ff == FADE_WIDTH'(1)) begin
                        fade_active_ff <= 1'b0;
                        for (int c = 0; c < NUM_CHAN; c++) begin
                           shown_ff[c] <= {target_ff[c], {FRACTION_BITS{1'b0}}};
                           step_ff[c]  <= '0;
                        end
                     end else begin
                        for (int c = 0; c < NUM_CHAN; c++) begin
                           shown_ff[c] <= shown_ff[c] + step_ff[c][LW-1:0];
                        end
                     end
                  end else begin
                     ms_ff <= ms_ff + PERIOD_WIDTH'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_build.red_drive     = ~shown_int[0];
      rsp_build.green_drive   = ~shown_int[1];
      rsp_build.blue_drive    = ~shown_int[2];
      rsp_build.fading        = fade_active_ff;
      rsp_build.color_updated = (shown_int[0] != before_ff[0]) ||
                                (shown_int[1] != before_ff[1]) ||
                                (shown_int[2] != before_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_FINISH && out_free) begin
         rsp_valid_ff <= 1'b1;
         rsp_data_ff  <= rsp_build;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `RFE_ASSERT(a_active_has_frames, fade_active_ff |-> (frames_left_ff != '0),
               "fade active with no frames left")
   `RFE_ASSERT(a_div_done_in_use,
               div_done |-> (state_ff == ST_FRAMES || state_ff == ST_STEP),
               "divider finished outside a division")
   `RFE_ASSERT(a_accept_leaves_idle, (req_valid && !req_stall) |=> (state_ff != ST_IDLE),
               "accepted transaction left engine idle")
   `RFE_ASSERT_ALWAYS(a_reset_clears_output, reset |=> !rsp_valid,
                      "result valid right after reset")

endmodule

`default_nettype wire
